// ===== src/pointer_axis_snapping_core_assert.svh =====
// ----------------------------------------------------------------------------
// pointer_axis_snapping_core_assert.svh
// Assertion macros for the pointer axis snapping RTL.
// ----------------------------------------------------------------------------
`ifndef POINTER_AXIS_SNAPPING_CORE_ASSERT_SVH
`define POINTER_AXIS_SNAPPING_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PAS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pointer axis snapping: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pointer axis snapping: next-cycle check failed");

`endif

// ===== src/pas_pkg.sv =====
// ----------------------------------------------------------------------------
// pas_pkg
// Types and constants for the pointer axis snapping block.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int COUNT_W  = 16;   // motion counts, two's complement
    localparam int RATIO_W  = 12;   // leak ratio, unsigned Q4.8
    localparam int THRESH_W = 16;   // switch threshold in whole counts
    localparam int DRIFT_W  = 32;   // drift, signed with 8 fraction bits
    localparam int FRAC_W   = 8;
    localparam int CFG_W    = 16;   // widest configuration register

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t REG_SNAP_ENABLE      = 2'd0;
    localparam cfg_index_t REG_DRIFT_RATIO      = 2'd1;
    localparam cfg_index_t REG_SWITCH_THRESHOLD = 2'd2;

    typedef enum logic [1:0] {
        AXIS_UNDECIDED  = 2'd0,
        AXIS_HORIZONTAL = 2'd1,
        AXIS_VERTICAL   = 2'd2
    } axis_mode_t;

    typedef struct packed {
        logic                enable;
        logic [RATIO_W-1:0]  ratio;
        logic [THRESH_W-1:0] threshold;
    } snap_cfg_t;

    typedef struct packed {
        axis_mode_t                mode;
        logic signed [DRIFT_W-1:0] drift;
    } snap_state_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] out_x;
        logic signed [COUNT_W-1:0] out_y;
        snap_state_t               state;
    } snap_result_t;

endpackage

// ===== src/pas_snap_unit.sv =====
// ----------------------------------------------------------------------------
// pas_snap_unit
// One report step: axis decision, drift tracking with leak, axis switch.
// ----------------------------------------------------------------------------
module pas_snap_unit (
    input  pas_pkg::snap_cfg_t                  cfg,
    input  pas_pkg::snap_state_t                state,
    input  logic signed [pas_pkg::COUNT_W-1:0]  dx,
    input  logic signed [pas_pkg::COUNT_W-1:0]  dy,
    output pas_pkg::snap_result_t               result
);
    import pas_pkg::*;

    logic signed [COUNT_W:0]   ext_x;
    logic signed [COUNT_W:0]   ext_y;
    logic [COUNT_W:0]          mag_x;
    logic [COUNT_W:0]          mag_y;
    logic                      horiz;
    logic signed [COUNT_W-1:0] off_axis;
    logic [COUNT_W:0]          mag_on;
    logic [28:0]               leak;
    logic signed [DRIFT_W:0]   d_sum;
    logic signed [DRIFT_W:0]   d_leak;
    logic signed [DRIFT_W:0]   d_diff;
    logic signed [DRIFT_W-1:0] d_sat;
    logic [DRIFT_W-1:0]        d_mag;
    logic [DRIFT_W-1:0]        thr_fix;
    logic                      do_switch;

    // Magnitudes, exact for the most negative count
    assign ext_x = {dx[COUNT_W-1], dx};
    assign ext_y = {dy[COUNT_W-1], dy};
    assign mag_x = ext_x[COUNT_W] ? (COUNT_W+1)'(-ext_x) : (COUNT_W+1)'(ext_x);
    assign mag_y = ext_y[COUNT_W] ? (COUNT_W+1)'(-ext_y) : (COUNT_W+1)'(ext_y);

    assign horiz    = (state.mode == AXIS_HORIZONTAL);
    assign off_axis = horiz ? dy : dx;
    assign mag_on   = horiz ? mag_x : mag_y;

    assign leak  = {12'd0, mag_on} * {17'd0, cfg.ratio};
    assign d_sum = {state.drift[DRIFT_W-1], state.drift}
                 + {{(DRIFT_W+1-COUNT_W-FRAC_W){off_axis[COUNT_W-1]}}, off_axis, 8'd0};

    // Leak toward zero, never past it
    always_comb
    begin
        d_diff = d_sum;
        d_leak = d_sum;
        if (!d_sum[DRIFT_W] && (d_sum != '0))
        begin
            d_diff = d_sum - {4'd0, leak};
            d_leak = d_diff[DRIFT_W] ? '0 : d_diff;
        end
        else if (d_sum[DRIFT_W])
        begin
            d_diff = d_sum + {4'd0, leak};
            d_leak = (!d_diff[DRIFT_W] && (d_diff != '0)) ? '0 : d_diff;
        end
    end

    always_comb
    begin
        if (d_leak[DRIFT_W] != d_leak[DRIFT_W-1])
            d_sat = d_leak[DRIFT_W] ? {1'b1, {(DRIFT_W-1){1'b0}}}
                                    : {1'b0, {(DRIFT_W-1){1'b1}}};
        else
            d_sat = d_leak[DRIFT_W-1:0];
    end

    assign d_mag     = d_sat[DRIFT_W-1] ? DRIFT_W'(-d_sat) : DRIFT_W'(d_sat);
    assign thr_fix   = {8'd0, cfg.threshold, 8'd0};
    assign do_switch = (d_mag > thr_fix);

    always_comb
    begin
        result.out_x = dx;
        result.out_y = dy;
        result.state = state;
        if (cfg.enable)
        begin
            case (state.mode)
                AXIS_HORIZONTAL:
                begin
                    if (do_switch)
                    begin
                        result.out_x       = '0;
                        result.state.drift = '0;
                        result.state.mode  = AXIS_VERTICAL;
                    end
                    else
                    begin
                        result.out_y       = '0;
                        result.state.drift = d_sat;
                    end
                end
                AXIS_VERTICAL:
                begin
                    if (do_switch)
                    begin
                        result.out_y       = '0;
                        result.state.drift = '0;
                        result.state.mode  = AXIS_HORIZONTAL;
                    end
                    else
                    begin
                        result.out_x       = '0;
                        result.state.drift = d_sat;
                    end
                end
                default:
                begin
                    if (mag_x > mag_y)
                    begin
                        result.out_y      = '0;
                        result.state.mode = AXIS_HORIZONTAL;
                    end
                    else if (mag_x < mag_y)
                    begin
                        result.out_x      = '0;
                        result.state.mode = AXIS_VERTICAL;
                    end
                end
            endcase
        end
    end

endmodule

// ===== src/pointer_axis_snapping_core.sv =====
// ----------------------------------------------------------------------------
// pointer_axis_snapping_core
// Snaps pointer motion reports to one axis with drift-based axis switching.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_axis: tdata carries dx in [15:0], dy in [31:16].
//   Each input beat yields exactly one output beat on m_axis: tdata carries
//   out_x in [15:0], out_y in [31:16]; tuser carries locked_axis in [1:0].
//   A beat is registered on entry in the input register, processed there by the
//   snap unit and registered again on exit in the output register. While
//   m_axis_tready stays high, one beat a cycle is sustained; the limit is the
//   drift register, which feeds back from one beat to the next through an add,
//   one 17x12 multiply, a leak add or subtract and a clamp.
//   When the receiver stalls, the output register holds its beat and the
//   input register takes one more; after that s_axis_tready drops until
//   m_axis_tready returns. Nothing is lost or repeated.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle.
//   Writing snap_enable from 0 to 1 clears axis mode and drift.
//   Reset empties both registers and restores snap_enable 0, drift_ratio 256,
//   switch_threshold 32, axis undecided and zero drift.
// ----------------------------------------------------------------------------
module pointer_axis_snapping_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // dx[15:0], dy[31:16]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [31:0]                  m_axis_tdata,  // out_x[15:0], out_y[31:16]
    output logic [1:0]                   m_axis_tuser,  // locked_axis[1:0]
    input  logic                         cfg_we,
    input  pas_pkg::cfg_index_t          cfg_index,
    input  logic [pas_pkg::CFG_W-1:0]    cfg_data
);
    import pas_pkg::*;

    `include "pointer_axis_snapping_core_assert.svh"

    // Configuration registers
    logic                enable_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [THRESH_W-1:0] threshold_reg;

    // Snapping state, carried from beat to beat
    axis_mode_t                mode_reg;
    axis_mode_t                mode_next;
    logic signed [DRIFT_W-1:0] drift_reg;
    logic signed [DRIFT_W-1:0] drift_next;

    // Input register
    logic                      in_valid_reg;
    logic signed [COUNT_W-1:0] dx_reg;
    logic signed [COUNT_W-1:0] dy_reg;

    // Output register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [1:0]  out_axis_reg;

    logic         out_load;
    logic         step;
    logic         in_take;
    logic         enable_rise;
    snap_cfg_t    cfg;
    snap_state_t  state;
    snap_result_t result;

    // Advance the output register when it is empty or being drained
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_load;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign enable_rise = cfg_we && (cfg_index == REG_SNAP_ENABLE)
                       && cfg_data[0] && !enable_reg;

    assign cfg   = '{enable: enable_reg, ratio: ratio_reg, threshold: threshold_reg};
    assign state = '{mode: mode_reg, drift: drift_reg};

    pas_snap_unit u_snap (
        .cfg    (cfg),
        .state  (state),
        .dx     (dx_reg),
        .dy     (dy_reg),
        .result (result)
    );

    // Clear on a rising enable; otherwise take the step's state
    always_comb
    begin
        mode_next  = mode_reg;
        drift_next = drift_reg;
        if (enable_rise)
        begin
            mode_next  = AXIS_UNDECIDED;
            drift_next = '0;
        end
        else if (step)
        begin
            mode_next  = result.state.mode;
            drift_next = result.state.drift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            ratio_reg     <= RATIO_W'(256);
            threshold_reg <= THRESH_W'(32);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SNAP_ENABLE:      enable_reg    <= cfg_data[0];
                REG_DRIFT_RATIO:      ratio_reg     <= cfg_data[RATIO_W-1:0];
                REG_SWITCH_THRESHOLD: threshold_reg <= cfg_data[THRESH_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= AXIS_UNDECIDED;
            drift_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            drift_reg <= drift_next;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Payload: hold unless a beat moves in
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dx_reg <= s_axis_tdata[15:0];
            dy_reg <= s_axis_tdata[31:16];
        end
        if (step)
        begin
            out_data_reg <= {result.out_y, result.out_x};
            out_axis_reg <= result.state.mode;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_axis_reg;

    // An undecided axis always carries zero drift
    `PAS_ASSERT_NOW(a_undecided_no_drift, clk, rst_n,
        mode_reg == AXIS_UNDECIDED, drift_reg == '0)

    // A beat leaving the input register lands in the output register
    `PAS_ASSERT_NEXT(a_step_fills_output, clk, rst_n, step, out_valid_reg)

    // Disabled beats leave the snapping state untouched
    `PAS_ASSERT_NEXT(a_disabled_keeps_state, clk, rst_n,
        step && !enable_reg && !cfg_we, $stable(mode_reg) && $stable(drift_reg))

endmodule

// ===== dv/pointer_axis_snapping_checker.sv =====
// ----------------------------------------------------------------------------
// pointer_axis_snapping_checker
// Watches the configuration port and both stream channels of the snapping
// core. Predicts every output beat from the accepted input beats with its
// own copy of the axis mode, the drift and the registers, and compares each
// accepted output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pointer_axis_snapping_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,  // dx[15:0], dy[31:16]
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [31:0]                 m_axis_tdata,  // out_x[15:0], out_y[31:16]
    input  logic [1:0]                  m_axis_tuser,  // locked_axis[1:0]
    input  logic                        cfg_we,
    input  pas_pkg::cfg_index_t         cfg_index,
    input  logic [pas_pkg::CFG_W-1:0]   cfg_data,
    output int                          mismatches,
    output int                          outstanding
);
    import pas_pkg::*;

    typedef struct packed {
        logic signed [COUNT_W-1:0] x;
        logic signed [COUNT_W-1:0] y;
        axis_mode_t                axis;
    } snapped_report_t;

    snapped_report_t     snapped_queue[$];

    logic                snap_on;
    logic [RATIO_W-1:0]  leak_ratio;
    logic [THRESH_W-1:0] switch_level;
    axis_mode_t          held_axis;
    longint              drift;         // 8 fraction bits

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Add the off-axis motion, leak toward zero by the on-axis motion and
    // tell whether the drift now lies beyond the switch level.
    function automatic bit drift_crosses(input longint off_axis, input longint on_axis);
        longint d;
        longint leak;
        d    = drift + off_axis * 256;
        leak = magnitude(on_axis) * longint'(leak_ratio);
        if (d > 0)
        begin
            d = d - leak;
            if (d < 0)
                d = 0;
        end
        else if (d < 0)
        begin
            d = d + leak;
            if (d > 0)
                d = 0;
        end
        if (d > 64'sd2147483647)
            d = 64'sd2147483647;
        if (d < -64'sd2147483648)
            d = -64'sd2147483648;
        drift = d;
        return magnitude(d) > longint'(switch_level) * 256;
    endfunction

    function automatic snapped_report_t snap_motion(input logic signed [COUNT_W-1:0] dx,
                                                    input logic signed [COUNT_W-1:0] dy);
        snapped_report_t r;
        r.x = dx;
        r.y = dy;
        if (snap_on)
        begin
            case (held_axis)
                AXIS_HORIZONTAL:
                begin
                    if (drift_crosses(dy, dx))
                    begin
                        r.x       = '0;
                        drift     = 0;
                        held_axis = AXIS_VERTICAL;
                    end
                    else
                        r.y = '0;
                end
                AXIS_VERTICAL:
                begin
                    if (drift_crosses(dx, dy))
                    begin
                        r.y       = '0;
                        drift     = 0;
                        held_axis = AXIS_HORIZONTAL;
                    end
                    else
                        r.x = '0;
                end
                default:
                begin
                    if (magnitude(dx) > magnitude(dy))
                    begin
                        r.y       = '0;
                        held_axis = AXIS_HORIZONTAL;
                    end
                    else if (magnitude(dx) < magnitude(dy))
                    begin
                        r.x       = '0;
                        held_axis = AXIS_VERTICAL;
                    end
                end
            endcase
        end
        r.axis = held_axis;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] snapped beat mismatch on %s: got %0d, want %0d",
                 $time, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        snapped_report_t want;
        if (!rst_n)
        begin
            snap_on      = 1'b0;
            leak_ratio   = RATIO_W'(256);
            switch_level = THRESH_W'(32);
            held_axis    = AXIS_UNDECIDED;
            drift        = 0;
            mismatches   = 0;
            snapped_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SNAP_ENABLE:
                    begin
                        if (cfg_data[0] && !snap_on)
                        begin
                            held_axis = AXIS_UNDECIDED;
                            drift     = 0;
                        end
                        snap_on = cfg_data[0];
                    end
                    REG_DRIFT_RATIO:      leak_ratio   = cfg_data[RATIO_W-1:0];
                    REG_SWITCH_THRESHOLD: switch_level = cfg_data[THRESH_W-1:0];
                    default: ;
                endcase
            end

            // Retire before predicting, so a stray beat never meets its own prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (snapped_queue.size() == 0)
                    report_mismatch("unexpected beat, locked_axis", int'(m_axis_tuser), -1);
                else
                begin
                    want = snapped_queue.pop_front();
                    if (m_axis_tdata[15:0] !== want.x)
                        report_mismatch("out_x", int'($signed(m_axis_tdata[15:0])),
                                        int'(want.x));
                    if (m_axis_tdata[31:16] !== want.y)
                        report_mismatch("out_y", int'($signed(m_axis_tdata[31:16])),
                                        int'(want.y));
                    if (m_axis_tuser !== want.axis)
                        report_mismatch("locked_axis", int'(m_axis_tuser), int'(want.axis));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                snapped_queue.push_back(snap_motion(s_axis_tdata[15:0], s_axis_tdata[31:16]));

            outstanding <= snapped_queue.size();
        end
    end

endmodule

// ===== dv/pointer_axis_snapping_core_tb.sv =====
// ----------------------------------------------------------------------------
// pointer_axis_snapping_core_tb
// Drives motion reports into the snapping core under several register
// settings and leaves prediction and comparison to the checker beside it.
// A short directed run walks the pass-through, tie, lock, drift-leak and
// axis-switch cases; a long random run follows with bursty input, an
// irregular receiver and one long receiver hold-off.
// ----------------------------------------------------------------------------
module pointer_axis_snapping_core_tb;
    import pas_pkg::*;

    localparam int         LIMIT_CYCLES = 400000;
    localparam int         PHASES       = 8;
    localparam int         PHASE_BEATS  = 250;
    localparam int         HOLD_CYCLES  = 80;
    // Index with no register behind it: writes there must change nothing.
    localparam cfg_index_t REG_NONE     = 2'd3;

    // Receiver pacing modes.
    typedef enum logic [1:0] {
        PACE_FREE,      // always ready
        PACE_HALF,      // ready about half the time
        PACE_SPARSE,    // ready about one cycle in four
        PACE_EAGER      // ready about three quarters of the time
    } pace_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;   // dx[15:0], dy[31:16]
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [31:0]      m_axis_tdata;   // out_x[15:0], out_y[31:16]
    logic [1:0]       m_axis_tuser;   // locked_axis[1:0]
    logic             cfg_we;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int               mismatches;
    int               outstanding;
    int               cycle_count = 0;

    // Receiver state: pacing mode, its remaining span and the long hold-off.
    logic             hold_request;
    logic             hold_taken = 1'b0;
    int               hold_left  = 0;
    int               span_left  = 0;
    pace_t            pace       = PACE_FREE;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pointer_axis_snapping_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    pointer_axis_snapping_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: stall on a pattern of its own. When the sender asks for
    // back-pressure, hold off for a long stretch counted here, once.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_request && !hold_taken)
        begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (span_left == 0)
            begin
                pace      <= pace_t'($urandom_range(0, 3));
                span_left <= $urandom_range(8, 120);
            end
            else
                span_left <= span_left - 1;
            case (pace)
                PACE_FREE:   m_axis_tready <= 1'b1;
                PACE_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 0);
                PACE_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:     m_axis_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Offer one report and hold it until the core takes the beat. Leave
    // tvalid high so a following beat goes out back to back.
    task automatic send_report(input logic signed [COUNT_W-1:0] dx,
                               input logic signed [COUNT_W-1:0] dy);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dy, dx};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop tvalid and wait until every predicted beat has come back.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // One write a cycle; the caller lowers cfg_we after the last of a batch.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic reconfigure(input logic enable, input logic [RATIO_W-1:0] ratio,
                               input logic [THRESH_W-1:0] threshold);
        wait_idle();
        write_reg(REG_SNAP_ENABLE, CFG_W'(enable));
        write_reg(REG_DRIFT_RATIO, CFG_W'(ratio));
        write_reg(REG_SWITCH_THRESHOLD, threshold);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COUNT_W-1:0] extreme_count(input int pick);
        case (pick)
            0:       return -16'sd32768;
            1:       return -16'sd1;
            2:       return 16'sd0;
            3:       return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    initial
    begin
        int                        phase;
        int                        n;
        int                        burst_left;
        int                        roll;
        int                        on_count;
        int                        off_count;
        logic signed [COUNT_W-1:0] dx;
        logic signed [COUNT_W-1:0] dy;
        logic                      enable;
        logic [RATIO_W-1:0]        ratio;
        logic [THRESH_W-1:0]       threshold;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_SNAP_ENABLE;
        cfg_data      <= '0;
        hold_request  <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Disabled out of reset: reports pass untouched.
        send_report(16'sd32767, -16'sd32768);
        send_report(-16'sd32768, 16'sd32767);

        reconfigure(1'b1, 12'd256, 16'd32);
        send_report(16'sd0, 16'sd0);             // zero motion: stays undecided
        send_report(16'sd5, -16'sd5);            // tie: stays undecided
        send_report(-16'sd32768, 16'sd32767);    // lock horizontal
        send_report(16'sd10, 16'sd3);            // positive drift leaks to zero
        send_report(16'sd10, -16'sd3);           // negative drift leaks to zero
        send_report(16'sd0, 16'sd20);            // drift builds, no switch yet
        send_report(16'sd0, 16'sd20);            // crosses: switch to vertical
        send_report(-16'sd40, 16'sd0);           // crosses straight back
        send_report(16'sd32767, -16'sd32768);    // full-scale drift against full leak

        // Disable keeps the axis and the drift; locked_axis still shows it.
        wait_idle();
        write_reg(REG_SNAP_ENABLE, CFG_W'(0));
        cfg_we <= 1'b0;
        send_report(16'sd3, 16'sd100);

        // Re-enable clears the axis.
        wait_idle();
        write_reg(REG_SNAP_ENABLE, CFG_W'(1));
        cfg_we <= 1'b0;
        send_report(16'sd7, 16'sd7);
        send_report(16'sd1, -16'sd2);

        // Enable again while enabled, and a write to an empty index: no effect.
        wait_idle();
        write_reg(REG_SNAP_ENABLE, CFG_W'(1));
        write_reg(REG_NONE, '1);
        cfg_we <= 1'b0;
        send_report(16'sd0, 16'sd5);

        // No leak and zero threshold: any off-axis count switches.
        reconfigure(1'b1, 12'd0, 16'd0);
        send_report(16'sd1, 16'sd0);
        send_report(16'sd0, -16'sd1);
        send_report(-16'sd32768, -16'sd32768);

        // Largest leak and threshold.
        reconfigure(1'b1, 12'd4095, 16'd65535);
        send_report(-16'sd32768, 16'sd32767);
        send_report(16'sd0, -16'sd32768);
        send_report(16'sd0, -16'sd32768);

        // Random phases, each under its own register setting.
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                ratio     = '0;
                threshold = '0;
            end
            else if (phase == 1)
            begin
                ratio     = '1;
                threshold = '1;
            end
            else
            begin
                ratio     = RATIO_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                                 : $urandom_range(0, 96));
                threshold = THRESH_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                  : $urandom_range(0, 120));
            end
            enable = (phase % 5 != 4);

            // Now and then pass through disabled first, so the enable clears state.
            if (enable && $urandom_range(0, 1) == 0)
            begin
                wait_idle();
                write_reg(REG_SNAP_ENABLE, CFG_W'(0));
            end
            reconfigure(enable, ratio, threshold);

            burst_left = $urandom_range(1, 24);
            // Ask for the long hold-off and keep offering beats into it.
            if (phase == 2)
            begin
                hold_request <= 1'b1;
                burst_left = 40;
            end

            for (n = 0; n < PHASE_BEATS; n++)
            begin
                if (burst_left == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                            : $urandom_range(1, 24);
                end
                burst_left--;

                roll = $urandom_range(0, 15);
                if (roll == 0)
                begin
                    dx = COUNT_W'($urandom);
                    dy = COUNT_W'($urandom);
                end
                else if (roll == 1)
                begin
                    dx = extreme_count($urandom_range(0, 4));
                    dy = extreme_count($urandom_range(0, 4));
                end
                else
                begin
                    // Mostly one dominant axis with a little sideways wander,
                    // which is what builds drift and drives switching.
                    on_count  = $urandom_range(0, (roll == 2) ? 2000 : 60);
                    off_count = $urandom_range(0, 14);
                    if ($urandom_range(0, 1) == 0)
                        on_count = -on_count;
                    if ($urandom_range(0, 1) == 0)
                        off_count = -off_count;
                    if (roll < 9)
                    begin
                        dx = COUNT_W'(on_count);
                        dy = COUNT_W'(off_count);
                    end
                    else
                    begin
                        dx = COUNT_W'(off_count);
                        dy = COUNT_W'(on_count);
                    end
                end
                send_report(dx, dy);
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
